@@ rtl/sparse_rating_matrix_builder_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sparse rating matrix builder
// Implication checks, same-cycle and next-cycle, gated by reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_RATING_MATRIX_BUILDER_CORE_ASSERT_SVH
`define SPARSE_RATING_MATRIX_BUILDER_CORE_ASSERT_SVH

// same-cycle implication
`define SRMB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srmb check failed");

// next-cycle implication
`define SRMB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srmb check failed");

`endif

@@ rtl/srmb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmb_pkg
// Sizes, record layout, mode and status codes of the rating matrix builder.
// ----------------------------------------------------------------------------
package srmb_pkg;
    localparam int MAX_USERS   = 1024;
    localparam int MAX_ITEMS   = 1024;
    localparam int MAX_RATINGS = 4096;
    localparam int UID_W  = 10;
    localparam int IID_W  = 10;
    localparam int RAT_W  = 16;
    localparam int REC_W  = UID_W + IID_W + RAT_W;
    localparam int RADDR_W = 12;
    localparam int CNT_W  = 13;
    localparam int SUM_W  = 28;
    localparam int CFG_W  = 11;
    localparam int KEY_W  = 11;

    localparam logic [2:0] MODE_LOAD   = 3'd0;
    localparam logic [2:0] MODE_BUILD  = 3'd1;
    localparam logic [2:0] MODE_LOOKUP = 3'd2;
    localparam logic [2:0] MODE_SUB_U  = 3'd3;
    localparam logic [2:0] MODE_SUB_I  = 3'd4;
    localparam logic [2:0] MODE_CLEAR  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_NOBLD = 2'd3;

    localparam logic CFG_USER_COUNT = 1'b0;
    localparam logic CFG_ITEM_COUNT = 1'b1;

    typedef struct packed {
        logic signed [RAT_W-1:0] rating;
        logic [IID_W-1:0]        item;
        logic [UID_W-1:0]        user;
    } t_rec;
endpackage

@@ rtl/srmb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmb_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module srmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/sparse_rating_matrix_builder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_rating_matrix_builder_core
// Rating store: load, build sorted rows and means, lookup, centering, clear.
// ----------------------------------------------------------------------------
// Usage:
// One command beat enters on the slave stream; tuser carries the mode, tdata
// the user id, item id and rating. Every command gives exactly one result
// beat on the master stream (rating, found flag, status).
// Only one command is in flight: tready is high while the core is idle and
// the result register is empty. A stalled master holds the result and the
// core takes no new beat until it leaves.
// Rejected commands and unused modes are answered from idle; load reads
// and updates the sums and tallies; lookup is a binary search over the
// user's row (up to 13 steps), plus a read of a candidate record if one
// is left; centering reads, adjusts and writes back each record; build
// runs user and item mean dividers, two bucket prefix passes and two
// scatter passes. Each store has one RAM port; the divider is bit-serial.
// Clear and reset run a clearing pass over the sum, tally and mean RAMs;
// tready stays low until it ends. Configuration writes are taken any time.
// ----------------------------------------------------------------------------
`include "sparse_rating_matrix_builder_core_assert.svh"

module sparse_rating_matrix_builder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [9:0] user_id, [19:10] item_id, [35:20] rating_value, [39:36] zero
    input  logic [39:0]                 i_s_axis_tdata,
    // [2:0] mode
    input  logic [2:0]                  i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [15:0] rating_out, [16] found, [18:17] status, [23:19] zero
    output logic [23:0]                 o_m_axis_tdata,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_addr,
    input  logic [srmb_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import srmb_pkg::*;

    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_LD_RD   = 5'd2;
    localparam logic [4:0] S_LD_WR   = 5'd3;
    localparam logic [4:0] S_MN_RD   = 5'd4;
    localparam logic [4:0] S_MN_LAT  = 5'd5;
    localparam logic [4:0] S_MN_UDIV = 5'd6;
    localparam logic [4:0] S_MN_IDIV = 5'd7;
    localparam logic [4:0] S_PRE_RD  = 5'd8;
    localparam logic [4:0] S_PRE_WR  = 5'd9;
    localparam logic [4:0] S_SC_RD   = 5'd10;
    localparam logic [4:0] S_SC_LAT  = 5'd11;
    localparam logic [4:0] S_SC_BR   = 5'd12;
    localparam logic [4:0] S_SC_WR   = 5'd13;
    localparam logic [4:0] S_LK_RD   = 5'd14;
    localparam logic [4:0] S_LK_LAT  = 5'd15;
    localparam logic [4:0] S_LK_CMP  = 5'd16;
    localparam logic [4:0] S_LK_CHK  = 5'd17;
    localparam logic [4:0] S_LK_FIN  = 5'd18;
    localparam logic [4:0] S_CT_RD   = 5'd19;
    localparam logic [4:0] S_CT_MN   = 5'd20;
    localparam logic [4:0] S_CT_WR   = 5'd21;

    localparam int DCNT_W = $clog2(SUM_W + 1);

    // control and payload registers
    logic [4:0]              r_state, n_state;
    logic [CFG_W-1:0]        r_user_count, n_user_count;
    logic [CFG_W-1:0]        r_item_count, n_item_count;
    logic [CNT_W-1:0]        r_total, n_total;
    logic                    r_built, n_built;
    logic                    r_clr_resp, n_clr_resp;
    logic                    r_out_valid, n_out_valid;
    logic [RAT_W-1:0]        r_out_rating, n_out_rating;
    logic                    r_out_found, n_out_found;
    logic [1:0]              r_out_status, n_out_status;
    logic [2:0]              r_mode, n_mode;
    logic [UID_W-1:0]        r_user, n_user;
    logic [IID_W-1:0]        r_item, n_item;
    logic [RAT_W-1:0]        r_rating, n_rating;
    logic [KEY_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_i, n_i;
    logic [CNT_W-1:0]        r_run, n_run;
    logic                    r_pass, n_pass;
    t_rec                    r_rec, n_rec;
    logic [CNT_W-1:0]        r_lo, n_lo;
    logic [CNT_W-1:0]        r_hi, n_hi;
    logic [CNT_W-1:0]        r_mid, n_mid;
    logic [CNT_W:0]          r_lim, n_lim;
    logic [SUM_W-1:0]        r_dq, n_dq;
    logic [CNT_W:0]          r_acc, n_acc;
    logic [CNT_W-1:0]        r_den, n_den;
    logic                    r_neg, n_neg;
    logic [DCNT_W-1:0]       r_dcnt, n_dcnt;
    logic [SUM_W-1:0]        r_isum, n_isum;
    logic [CNT_W-1:0]        r_itally, n_itally;

    // RAM ports
    logic [RADDR_W-1:0] ld_addr, sc_addr, so_addr;
    logic               ld_we, sc_we, so_we;
    logic [REC_W-1:0]   ld_wd, sc_wd, so_wd, ld_rd, sc_rd, so_rd;
    logic [UID_W-1:0]   us_addr, ut_addr, um_addr, rs_addr, bk_addr;
    logic [IID_W-1:0]   is_addr, it_addr, im_addr;
    logic               us_we, ut_we, um_we, rs_we, bk_we, is_we, it_we, im_we;
    logic [SUM_W-1:0]   us_wd, us_rd, is_wd, is_rd;
    logic [CNT_W-1:0]   ut_wd, ut_rd, it_wd, it_rd, rs_wd, rs_rd, bk_wd, bk_rd;
    logic [RAT_W-1:0]   um_wd, um_rd, im_wd, im_rd;

    srmb_ram #(.WIDTH(REC_W), .DEPTH(MAX_RATINGS)) u_loaded (
        .i_clk(i_clk), .i_addr(ld_addr), .i_we(ld_we), .i_wdata(ld_wd), .o_rdata(ld_rd));
    srmb_ram #(.WIDTH(REC_W), .DEPTH(MAX_RATINGS)) u_scratch (
        .i_clk(i_clk), .i_addr(sc_addr), .i_we(sc_we), .i_wdata(sc_wd), .o_rdata(sc_rd));
    srmb_ram #(.WIDTH(REC_W), .DEPTH(MAX_RATINGS)) u_sorted (
        .i_clk(i_clk), .i_addr(so_addr), .i_we(so_we), .i_wdata(so_wd), .o_rdata(so_rd));
    srmb_ram #(.WIDTH(SUM_W), .DEPTH(MAX_USERS)) u_usum (
        .i_clk(i_clk), .i_addr(us_addr), .i_we(us_we), .i_wdata(us_wd), .o_rdata(us_rd));
    srmb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_USERS)) u_utally (
        .i_clk(i_clk), .i_addr(ut_addr), .i_we(ut_we), .i_wdata(ut_wd), .o_rdata(ut_rd));
    srmb_ram #(.WIDTH(RAT_W), .DEPTH(MAX_USERS)) u_umean (
        .i_clk(i_clk), .i_addr(um_addr), .i_we(um_we), .i_wdata(um_wd), .o_rdata(um_rd));
    srmb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_USERS)) u_rstart (
        .i_clk(i_clk), .i_addr(rs_addr), .i_we(rs_we), .i_wdata(rs_wd), .o_rdata(rs_rd));
    srmb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_USERS)) u_bucket (
        .i_clk(i_clk), .i_addr(bk_addr), .i_we(bk_we), .i_wdata(bk_wd), .o_rdata(bk_rd));
    srmb_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ITEMS)) u_isum (
        .i_clk(i_clk), .i_addr(is_addr), .i_we(is_we), .i_wdata(is_wd), .o_rdata(is_rd));
    srmb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ITEMS)) u_itally (
        .i_clk(i_clk), .i_addr(it_addr), .i_we(it_we), .i_wdata(it_wd), .o_rdata(it_rd));
    srmb_ram #(.WIDTH(RAT_W), .DEPTH(MAX_ITEMS)) u_imean (
        .i_clk(i_clk), .i_addr(im_addr), .i_we(im_we), .i_wdata(im_wd), .o_rdata(im_rd));

    // input unpacking
    logic             s_acc;
    logic [UID_W-1:0] in_user;
    logic [IID_W-1:0] in_item;
    logic [RAT_W-1:0] in_rating;
    logic             ids_ok;

    assign o_s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign s_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign in_user   = i_s_axis_tdata[UID_W-1:0];
    assign in_item   = i_s_axis_tdata[UID_W+IID_W-1:UID_W];
    assign in_rating = i_s_axis_tdata[REC_W-1:UID_W+IID_W];
    assign ids_ok    = ({1'b0, in_user} < r_user_count) && ({1'b0, in_item} < r_item_count);

    // divider step and result
    logic [CNT_W:0]   dv_try;
    logic             dv_ge;
    logic [RAT_W-1:0] dv_q;
    assign dv_try = {r_acc[CNT_W-1:0], r_dq[SUM_W-1]};
    assign dv_ge  = dv_try >= {1'b0, r_den};
    assign dv_q   = (r_den == '0) ? '0 :
                    (r_neg ? RAT_W'(-r_dq[RAT_W-1:0]) : r_dq[RAT_W-1:0]);

    // misc datapath
    t_rec                   ld_rec, sc_rec, so_rec;
    logic [CNT_W-1:0]       lk_mid;
    logic [CNT_W-1:0]       pre_tally;
    logic signed [RAT_W:0]  ct_diff;
    logic [RAT_W-1:0]       ct_mean, ct_sat;
    logic [UID_W-1:0]       sc_key;

    assign ld_rec    = t_rec'(ld_rd);
    assign sc_rec    = t_rec'(sc_rd);
    assign so_rec    = t_rec'(so_rd);
    assign lk_mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign pre_tally = r_pass ? ut_rd : it_rd;
    assign sc_key    = r_pass ? r_rec.user : r_rec.item;
    assign ct_mean   = (r_mode == MODE_SUB_U) ? um_rd : im_rd;
    assign ct_diff   = $signed({r_rec.rating[RAT_W-1], r_rec.rating})
                     - $signed({ct_mean[RAT_W-1], ct_mean});
    always_comb begin
        if (ct_diff > $signed(17'sd32767)) begin
            ct_sat = 16'h7fff;
        end else if (ct_diff < -$signed(17'sd32768)) begin
            ct_sat = 16'h8000;
        end else begin
            ct_sat = ct_diff[RAT_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;  n_user_count = r_user_count;  n_item_count = r_item_count;
        n_total = r_total;  n_built = r_built;  n_clr_resp = r_clr_resp;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_rating = r_out_rating;  n_out_found = r_out_found;
        n_out_status = r_out_status;
        n_mode = r_mode;  n_user = r_user;  n_item = r_item;  n_rating = r_rating;
        n_idx = r_idx;  n_i = r_i;  n_run = r_run;  n_pass = r_pass;  n_rec = r_rec;
        n_lo = r_lo;  n_hi = r_hi;  n_mid = r_mid;  n_lim = r_lim;
        n_dq = r_dq;  n_acc = r_acc;  n_den = r_den;  n_neg = r_neg;  n_dcnt = r_dcnt;
        n_isum = r_isum;  n_itally = r_itally;

        ld_addr = r_total[RADDR_W-1:0];  ld_we = 1'b0;
        ld_wd = {r_rating, r_item, r_user};
        sc_addr = r_i[RADDR_W-1:0];  sc_we = 1'b0;  sc_wd = r_rec;
        so_addr = r_i[RADDR_W-1:0];  so_we = 1'b0;  so_wd = r_rec;
        us_addr = r_user;  us_we = 1'b0;  us_wd = '0;
        ut_addr = r_user;  ut_we = 1'b0;  ut_wd = '0;
        um_addr = r_user;  um_we = 1'b0;  um_wd = '0;
        rs_addr = r_user;  rs_we = 1'b0;  rs_wd = r_run;
        bk_addr = r_idx[UID_W-1:0];  bk_we = 1'b0;  bk_wd = r_run;
        is_addr = r_item;  is_we = 1'b0;  is_wd = '0;
        it_addr = r_item;  it_we = 1'b0;  it_wd = '0;
        im_addr = r_item;  im_we = 1'b0;  im_wd = '0;

        if (i_cfg_we) begin
            if (i_cfg_addr == CFG_USER_COUNT) begin
                n_user_count = i_cfg_wdata;
            end else begin
                n_item_count = i_cfg_wdata;
            end
        end

        unique case (r_state)
            S_CLR: begin
                us_addr = r_idx[UID_W-1:0];  ut_addr = r_idx[UID_W-1:0];
                um_addr = r_idx[UID_W-1:0];  is_addr = r_idx[IID_W-1:0];
                it_addr = r_idx[IID_W-1:0];  im_addr = r_idx[IID_W-1:0];
                us_we = 1'b1;  ut_we = 1'b1;  um_we = 1'b1;
                is_we = 1'b1;  it_we = 1'b1;  im_we = 1'b1;
                n_total = '0;
                n_built = 1'b0;
                n_idx = r_idx + 1'b1;
                if (r_idx == KEY_W'(MAX_USERS - 1)) begin
                    n_state = S_IDLE;
                    if (r_clr_resp) begin
                        n_out_valid = 1'b1;  n_out_rating = '0;
                        n_out_found = 1'b0;  n_out_status = ST_OK;
                    end
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    n_mode = i_s_axis_tuser;  n_user = in_user;
                    n_item = in_item;  n_rating = in_rating;
                    n_out_rating = '0;  n_out_found = 1'b0;  n_out_status = ST_OK;
                    n_out_valid = 1'b1;
                    unique case (i_s_axis_tuser)
                        MODE_LOAD: begin
                            if (!ids_ok) begin
                                n_out_status = ST_RANGE;
                            end else if (r_total >= CNT_W'(MAX_RATINGS)) begin
                                n_out_status = ST_FULL;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state = S_LD_RD;
                            end
                        end
                        MODE_BUILD: begin
                            n_out_valid = 1'b0;
                            n_idx = '0;
                            n_state = S_MN_RD;
                        end
                        MODE_LOOKUP: begin
                            if (!r_built) begin
                                n_out_status = ST_NOBLD;
                            end else if (!ids_ok) begin
                                n_out_status = ST_RANGE;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state = S_LK_RD;
                            end
                        end
                        MODE_SUB_U, MODE_SUB_I: begin
                            if (!r_built) begin
                                n_out_status = ST_NOBLD;
                            end else begin
                                n_out_valid = 1'b0;
                                n_i = '0;
                                n_state = S_CT_RD;
                            end
                        end
                        MODE_CLEAR: begin
                            n_out_valid = 1'b0;
                            n_idx = '0;
                            n_clr_resp = 1'b1;
                            n_state = S_CLR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LD_RD: begin
                n_state = S_LD_WR;
            end
            S_LD_WR: begin
                us_we = 1'b1;  ut_we = 1'b1;  is_we = 1'b1;  it_we = 1'b1;  ld_we = 1'b1;
                us_wd = us_rd + SUM_W'($signed(r_rating));
                is_wd = is_rd + SUM_W'($signed(r_rating));
                ut_wd = ut_rd + 1'b1;
                it_wd = it_rd + 1'b1;
                n_total = r_total + 1'b1;
                n_built = 1'b0;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_MN_RD: begin
                us_addr = r_idx[UID_W-1:0];  ut_addr = r_idx[UID_W-1:0];
                is_addr = r_idx[IID_W-1:0];  it_addr = r_idx[IID_W-1:0];
                n_state = S_MN_LAT;
            end
            S_MN_LAT: begin
                n_isum = is_rd;  n_itally = it_rd;
                n_neg = us_rd[SUM_W-1];
                n_dq = us_rd[SUM_W-1] ? SUM_W'(-us_rd) : us_rd;
                n_den = ut_rd;  n_acc = '0;  n_dcnt = '0;
                n_state = S_MN_UDIV;
            end
            S_MN_UDIV, S_MN_IDIV: begin
                if (r_dcnt == DCNT_W'(SUM_W)) begin
                    n_acc = '0;  n_dcnt = '0;
                    if (r_state == S_MN_UDIV) begin
                        um_addr = r_idx[UID_W-1:0];  um_we = 1'b1;  um_wd = dv_q;
                        n_neg = r_isum[SUM_W-1];
                        n_dq = r_isum[SUM_W-1] ? SUM_W'(-r_isum) : r_isum;
                        n_den = r_itally;
                        n_state = S_MN_IDIV;
                    end else begin
                        im_addr = r_idx[IID_W-1:0];  im_we = 1'b1;  im_wd = dv_q;
                        n_idx = r_idx + 1'b1;
                        if (r_idx == KEY_W'(MAX_USERS - 1)) begin
                            n_idx = '0;  n_run = '0;  n_pass = 1'b0;
                            n_state = S_PRE_RD;
                        end else begin
                            n_state = S_MN_RD;
                        end
                    end
                end else begin
                    n_acc = dv_ge ? (dv_try - {1'b0, r_den}) : dv_try;
                    n_dq = {r_dq[SUM_W-2:0], dv_ge};
                    n_dcnt = r_dcnt + 1'b1;
                end
            end
            S_PRE_RD: begin
                ut_addr = r_idx[UID_W-1:0];  it_addr = r_idx[IID_W-1:0];
                n_state = S_PRE_WR;
            end
            S_PRE_WR: begin
                bk_we = 1'b1;
                rs_addr = r_idx[UID_W-1:0];
                rs_we = r_pass;
                n_run = r_run + pre_tally;
                n_idx = r_idx + 1'b1;
                n_state = S_PRE_RD;
                if (r_idx == KEY_W'(MAX_USERS - 1)) begin
                    n_i = '0;
                    n_state = S_SC_RD;
                end
            end
            S_SC_RD: begin
                ld_addr = r_i[RADDR_W-1:0];
                if (r_i == r_total) begin
                    if (!r_pass) begin
                        n_pass = 1'b1;  n_idx = '0;  n_run = '0;
                        n_state = S_PRE_RD;
                    end else begin
                        n_built = 1'b1;
                        n_out_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_SC_LAT;
                end
            end
            S_SC_LAT: begin
                n_rec = r_pass ? sc_rec : ld_rec;
                n_state = S_SC_BR;
            end
            S_SC_BR: begin
                bk_addr = sc_key;
                n_state = S_SC_WR;
            end
            S_SC_WR: begin
                bk_addr = sc_key;  bk_we = 1'b1;  bk_wd = bk_rd + 1'b1;
                if (r_pass) begin
                    so_addr = bk_rd[RADDR_W-1:0];  so_we = 1'b1;
                end else begin
                    sc_addr = bk_rd[RADDR_W-1:0];  sc_we = 1'b1;
                end
                n_i = r_i + 1'b1;
                n_state = S_SC_RD;
            end
            S_LK_RD: begin
                n_state = S_LK_LAT;
            end
            S_LK_LAT: begin
                n_lo  = rs_rd;
                n_lim = {1'b0, rs_rd} + {1'b0, ut_rd};
                n_hi  = (({1'b0, rs_rd} + {1'b0, ut_rd}) > {1'b0, r_total}) ?
                        r_total : CNT_W'(rs_rd + ut_rd);
                n_state = S_LK_CMP;
            end
            S_LK_CMP: begin
                if (r_lo < r_hi) begin
                    so_addr = lk_mid[RADDR_W-1:0];
                    n_mid = lk_mid;
                    n_state = S_LK_CHK;
                end else if (({1'b0, r_lo} < r_lim) && (r_lo < r_total)) begin
                    so_addr = r_lo[RADDR_W-1:0];
                    n_state = S_LK_FIN;
                end else begin
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LK_CHK: begin
                if (so_rec.item < r_item) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_LK_CMP;
            end
            S_LK_FIN: begin
                if (so_rec.item == r_item) begin
                    n_out_rating = so_rec.rating;
                    n_out_found = 1'b1;
                end
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_CT_RD: begin
                if (r_i == r_total) begin
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CT_MN;
                end
            end
            S_CT_MN: begin
                n_rec = so_rec;
                um_addr = so_rec.user;
                im_addr = so_rec.item;
                n_state = S_CT_WR;
            end
            S_CT_WR: begin
                so_we = 1'b1;
                so_wd = {ct_sat, r_rec.item, r_rec.user};
                n_i = r_i + 1'b1;
                n_state = S_CT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_user_count <= CFG_W'(MAX_USERS);
            r_item_count <= CFG_W'(MAX_ITEMS);
            r_total      <= '0;
            r_built      <= 1'b0;
            r_clr_resp   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_i          <= '0;
            r_pass       <= 1'b0;
            r_dcnt       <= '0;
        end else begin
            r_state      <= n_state;
            r_user_count <= n_user_count;
            r_item_count <= n_item_count;
            r_total      <= n_total;
            r_built      <= n_built;
            r_clr_resp   <= n_clr_resp;
            r_out_valid  <= n_out_valid;
            r_idx        <= n_idx;
            r_i          <= n_i;
            r_pass       <= n_pass;
            r_dcnt       <= n_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_rating <= n_out_rating;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
        r_mode   <= n_mode;
        r_user   <= n_user;
        r_item   <= n_item;
        r_rating <= n_rating;
        r_run    <= n_run;
        r_rec    <= n_rec;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_lim    <= n_lim;
        r_dq     <= n_dq;
        r_acc    <= n_acc;
        r_den    <= n_den;
        r_neg    <= n_neg;
        r_isum   <= n_isum;
        r_itally <= n_itally;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_status, r_out_found, r_out_rating};

    `SRMB_ASSERT_NOW(a_total_bound, 1'b1, r_total <= CNT_W'(MAX_RATINGS))
    `SRMB_ASSERT_NOW(a_ready_empty, o_s_axis_tready, !o_m_axis_tvalid)
    `SRMB_ASSERT_NEXT(a_accept_busy, s_acc, (r_state != S_IDLE) || r_out_valid)
    `SRMB_ASSERT_NOW(a_found_ok, r_out_valid && r_out_found, r_out_status == ST_OK)
endmodule
